// ===== rtl/core/rc4_pkg.sv =====
// Package for the RC4 stream cipher core.
// Holds the S-box geometry, the default key store size and the op codes.
// No dependencies.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int SBOX_SIZE         = 256;
  localparam int SBOX_AW           = 8;
  localparam int KEY_MAX_BYTES_DEF = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef logic [7:0] byte_t;

endpackage

// ===== rtl/core/rc4_if.sv =====
// Valid/ready channel interfaces for the RC4 stream cipher core.
// rc4_in_if carries one input item, rc4_out_if one result item; no dependencies.
`timescale 1ns / 1ps

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key_byte;
  logic       key_last;
  logic [7:0] data_byte;
  logic       restart_indices;

  modport source (output valid, op, key_byte, key_last, data_byte, restart_indices,
                  input ready);
  modport sink   (input valid, op, key_byte, key_last, data_byte, restart_indices,
                  output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

// ===== rtl/core/rc4_ram.sv =====
// Byte-wide RAM with one write port and one registered read port.
// Used for the S-box and the key store; depends on rc4_pkg.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int DEPTH = rc4_pkg::SBOX_SIZE,
  parameter int AW    = rc4_pkg::SBOX_AW
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  rc4_pkg::byte_t      wdata,
  input  logic [AW-1:0]       raddr,
  output rc4_pkg::byte_t      rdata
);
  import rc4_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rc4_stream_cipher.sv =====
// RC4 stream cipher top level: key store, S-box RAM and the sequencer around them.
// The last key item starts the key schedule: 256 identity writes, then 256 swap steps
// (states K_RD, K_ACC, K_W1, K_W2) on the single S-box write port. A data item runs
// P_J, P_SWAP, P_OUT (and P_HOLD while the output stalls) to its result; ready is low
// meanwhile. Reset clears the key count, the indices and the output valid; the S-box
// stays undefined until a key is scheduled. Depends on rc4_pkg, rc4_if and rc4_ram.
`timescale 1ns / 1ps

module rc4_stream_cipher #(
  parameter int KEY_MAX_BYTES = rc4_pkg::KEY_MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rc4_in_if.sink     in_chan,
  rc4_out_if.source  out_chan
);
  import rc4_pkg::*;

  localparam int KAW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int CW  = $clog2(KEY_MAX_BYTES + 1);
  localparam logic [CW-1:0] KEY_MAX = CW'(KEY_MAX_BYTES);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_K_INIT = 4'd1;
  localparam logic [3:0] ST_K_RD   = 4'd2;
  localparam logic [3:0] ST_K_ACC  = 4'd3;
  localparam logic [3:0] ST_K_W1   = 4'd4;
  localparam logic [3:0] ST_K_W2   = 4'd5;
  localparam logic [3:0] ST_P_J    = 4'd6;
  localparam logic [3:0] ST_P_SWAP = 4'd7;
  localparam logic [3:0] ST_P_OUT  = 4'd8;
  localparam logic [3:0] ST_P_HOLD = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] key_count_r, key_count_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [KAW-1:0] kidx_r, kidx_nxt;
  byte_t         n_r, n_nxt;
  byte_t         acc_r, acc_nxt;
  byte_t         i_r, i_nxt;
  byte_t         j_r, j_nxt;
  byte_t         si_r, si_nxt;
  byte_t         sj_r, sj_nxt;
  byte_t         t_r, t_nxt;
  byte_t         data_r, data_nxt;
  byte_t         res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  byte_t         out_byte_r, out_byte_nxt;

  logic          sbox_we;
  byte_t         sbox_waddr, sbox_wdata, sbox_raddr, sbox_rdata;
  logic          key_we;
  logic [KAW-1:0] key_waddr;
  byte_t         key_rdata;

  logic          in_fire;
  logic          out_free;
  logic [CW-1:0] cnt_after;
  byte_t         i_base, j_base, i_first;
  byte_t         acc_sum, j_sum, t_sum, ks, res;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.out_byte = out_byte_r;

  assign i_base  = in_chan.restart_indices ? 8'd0 : i_r;
  assign j_base  = in_chan.restart_indices ? 8'd0 : j_r;
  assign i_first = i_base + 8'd1;
  assign cnt_after = (key_count_r < KEY_MAX) ? key_count_r + CW'(1) : key_count_r;
  assign acc_sum = acc_r + sbox_rdata + key_rdata;
  assign j_sum   = j_r + sbox_rdata;
  assign t_sum   = si_r + sbox_rdata;

  // The keystream index may hit a just-swapped entry; the later write wins.
  assign ks  = (t_r == j_r) ? si_r : ((t_r == i_r) ? sj_r : sbox_rdata);
  assign res = data_r ^ ks;

  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    len_nxt       = len_r;
    kidx_nxt      = kidx_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    data_nxt      = data_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_byte_nxt  = out_byte_r;
    sbox_we       = 1'b0;
    sbox_waddr    = n_r;
    sbox_wdata    = n_r;
    sbox_raddr    = n_r;
    key_we        = 1'b0;
    key_waddr     = key_count_r[KAW-1:0];

    case (state_r)
      ST_IDLE: begin
        sbox_raddr = i_first;
        if (in_fire) begin
          if (in_chan.op == OP_KEY) begin
            key_we = (key_count_r < KEY_MAX);
            if (in_chan.key_last) begin
              len_nxt       = cnt_after;
              key_count_nxt = '0;
              n_nxt         = 8'd0;
              state_nxt     = ST_K_INIT;
            end else begin
              key_count_nxt = cnt_after;
            end
          end else begin
            i_nxt     = i_first;
            j_nxt     = j_base;
            data_nxt  = in_chan.data_byte;
            state_nxt = ST_P_J;
          end
        end
      end
      ST_K_INIT: begin
        sbox_we = 1'b1;
        n_nxt   = n_r + 8'd1;
        if (n_r == 8'hFF) begin
          acc_nxt   = 8'd0;
          kidx_nxt  = '0;
          state_nxt = ST_K_RD;
        end
      end
      ST_K_RD: begin
        state_nxt = ST_K_ACC;
      end
      ST_K_ACC: begin
        acc_nxt    = acc_sum;
        si_nxt     = sbox_rdata;
        sbox_raddr = acc_sum;
        state_nxt  = ST_K_W1;
      end
      ST_K_W1: begin
        sbox_we    = 1'b1;
        sbox_wdata = sbox_rdata;
        state_nxt  = ST_K_W2;
      end
      ST_K_W2: begin
        sbox_we    = 1'b1;
        sbox_waddr = acc_r;
        sbox_wdata = si_r;
        n_nxt      = n_r + 8'd1;
        if ((CW'(kidx_r) + CW'(1)) == len_r) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + KAW'(1);
        end
        if (n_r == 8'hFF) begin
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_K_RD;
        end
      end
      ST_P_J: begin
        si_nxt     = sbox_rdata;
        j_nxt      = j_sum;
        sbox_raddr = j_sum;
        state_nxt  = ST_P_SWAP;
      end
      ST_P_SWAP: begin
        sbox_we    = 1'b1;
        sbox_waddr = i_r;
        sbox_wdata = sbox_rdata;
        sj_nxt     = sbox_rdata;
        t_nxt      = t_sum;
        sbox_raddr = t_sum;
        state_nxt  = ST_P_OUT;
      end
      ST_P_OUT: begin
        sbox_we    = 1'b1;
        sbox_waddr = j_r;
        sbox_wdata = si_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res;
          state_nxt     = ST_IDLE;
        end else begin
          res_nxt   = res;
          state_nxt = ST_P_HOLD;
        end
      end
      ST_P_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_count_r <= '0;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    kidx_r     <= kidx_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    res_r      <= res_nxt;
    out_byte_r <= out_byte_nxt;
  end

  rc4_ram #(
    .DEPTH (SBOX_SIZE),
    .AW    (SBOX_AW)
  ) u_sbox (
    .clk   (clk),
    .we    (sbox_we),
    .waddr (sbox_waddr),
    .wdata (sbox_wdata),
    .raddr (sbox_raddr),
    .rdata (sbox_rdata)
  );

  rc4_ram #(
    .DEPTH (KEY_MAX_BYTES),
    .AW    (KAW)
  ) u_key_store (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_chan.key_byte),
    .raddr (kidx_r),
    .rdata (key_rdata)
  );

endmodule
